// ===== sv/fts_pkg.sv =====
// Shared types and constants of the task scheduler.
package fts_pkg;

	localparam int DEF_NUM_SLOTS = 16;
	localparam int CHUNK_MAX     = 16;
	localparam int PID_W         = 4;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_READY  = 2'd1,
		REQ_YIELD  = 2'd2,
		REQ_EXIT   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_SLOT    = 3'd1,
		ST_NO_STACK   = 3'd2,
		ST_IGNORED    = 3'd3,
		ST_NONE_READY = 3'd4
	} status_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [PID_W-1:0]   pid;
		logic               stack_granted;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [PID_W-1:0]   new_pid;
		logic               switched;
		logic [PID_W-1:0]   old_pid;
		logic [PID_W-1:0]   running_pid;
	} rsp_t;

	typedef struct packed {
		logic done;
		logic found;
	} find_t;

endpackage

// ===== sv/fifo_task_scheduler.sv =====
// Task table with a FIFO ready queue kept as next-links in a memory.
//
// Requests arrive on the req channel (valid/ready), one result per request
// leaves on the rsp channel (valid/ready) from an output register.
// A request is taken only while the block is idle. For yield, ready and
// exit the accept reads the link memory at the queue head, then the execute
// step updates the table, writes at most one link and loads the result.
// Create adds a free-slot scan between the two, one chunk of at most 16
// slots per cycle, until a free slot is found or the last chunk is done.
// After reset slot 0 (idle) runs, all others are free, the queue is empty;
// the link memory is not cleared, links are written before they are read.
// When the receiver stalls, the finished result waits in the output register
// and the block waits to retire the next request until that beat is taken.
module fifo_task_scheduler #(
	parameter int NUM_SLOTS = fts_pkg::DEF_NUM_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fts_pkg::rsp_t rsp
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int PW     = fts_pkg::PID_W;
	localparam int CMP_W  = (SLOT_W > PW) ? SLOT_W + 1 : PW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_EXEC
	} state_t;

	state_t               state_q;
	fts_pkg::req_t        req_s1;
	logic [SLOT_W-1:0]    head_q;
	logic [SLOT_W-1:0]    tail_q;
	logic                 empty_q;
	logic [SLOT_W-1:0]    cur_q;
	logic [NUM_SLOTS-1:0] ready_q;
	logic                 rsp_valid_q;
	fts_pkg::rsp_t        rsp_q;

	logic                 accept;
	logic                 exec_fire;
	logic [NUM_SLOTS-1:0] free_vec;
	fts_pkg::find_t       find_res;
	logic [SLOT_W-1:0]    find_slot;
	logic [SLOT_W-1:0]    link_rdata;

	logic [SLOT_W-1:0]    pid_slot;
	logic                 pid_bad;
	logic [SLOT_W-1:0]    n_head;
	logic [SLOT_W-1:0]    n_tail;
	logic                 n_empty;
	logic [SLOT_W-1:0]    n_cur;
	logic [NUM_SLOTS-1:0] n_ready;
	logic                 push_en;
	logic [SLOT_W-1:0]    push_slot;
	logic [SLOT_W-1:0]    nx;
	logic                 link_we;
	logic [SLOT_W-1:0]    link_waddr;
	logic [SLOT_W-1:0]    link_wdata;
	fts_pkg::status_t     r_status;
	logic [SLOT_W-1:0]    r_new;
	logic                 r_sw;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign exec_fire = (state_q == S_EXEC) && (!rsp_valid_q || rsp_ready);

	// slot 0 and the running slot are never free
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			free_vec[i] = (i != 0) && !ready_q[i] && (SLOT_W'(i) != cur_q);
		end
	end

	fts_free_search #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (req.req_type == fts_pkg::REQ_CREATE)),
		.free_vec (free_vec),
		.res      (find_res),
		.slot     (find_slot)
	);

	// head link is fetched at accept; nothing writes the memory until exec
	fts_link_ram #(
		.DEPTH (NUM_SLOTS),
		.W     (SLOT_W)
	) u_links (
		.clk   (clk),
		.we    (link_we && exec_fire),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (accept),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	assign pid_slot = SLOT_W'(req_s1.pid);
	assign pid_bad  = (req_s1.pid == '0)
		|| (CMP_W'(req_s1.pid) >= CMP_W'(NUM_SLOTS))
		|| (pid_slot == cur_q)
		|| ready_q[pid_slot];

	always_comb begin
		n_head     = head_q;
		n_tail     = tail_q;
		n_empty    = empty_q;
		n_cur      = cur_q;
		n_ready    = ready_q;
		push_en    = 1'b0;
		push_slot  = '0;
		nx         = '0;
		link_we    = 1'b0;
		link_waddr = tail_q;
		link_wdata = '0;
		r_status   = fts_pkg::ST_OK;
		r_new      = '0;
		r_sw       = 1'b0;

		unique case (req_s1.req_type)
			fts_pkg::REQ_CREATE: begin
				if (!find_res.found) begin
					r_status = fts_pkg::ST_NO_SLOT;
				end else if (!req_s1.stack_granted) begin
					r_status = fts_pkg::ST_NO_STACK;
				end else begin
					n_ready[find_slot] = 1'b1;
					push_en            = 1'b1;
					push_slot          = find_slot;
					r_new              = find_slot;
				end
			end
			fts_pkg::REQ_READY: begin
				if (pid_bad) begin
					r_status = fts_pkg::ST_IGNORED;
				end else begin
					n_ready[pid_slot] = 1'b1;
					push_en           = 1'b1;
					push_slot         = pid_slot;
				end
			end
			fts_pkg::REQ_YIELD: begin
				if (empty_q) begin
					r_status = fts_pkg::ST_NONE_READY;
				end else begin
					nx = head_q;
					if (head_q == tail_q) begin
						n_empty = 1'b1;
						n_head  = '0;
						n_tail  = '0;
					end else begin
						n_head = link_rdata;
					end
					if (cur_q != '0) begin
						n_ready[cur_q] = 1'b1;
						push_en        = 1'b1;
						push_slot      = cur_q;
					end
					n_ready[nx] = 1'b0;
					n_cur       = nx;
					r_new       = nx;
					r_sw        = 1'b1;
				end
			end
			fts_pkg::REQ_EXIT: begin
				if (cur_q == '0) begin
					r_status = fts_pkg::ST_IGNORED;
				end else begin
					if (!empty_q) begin
						nx = head_q;
						if (head_q == tail_q) begin
							n_empty = 1'b1;
							n_head  = '0;
							n_tail  = '0;
						end else begin
							n_head = link_rdata;
						end
					end
					n_ready[nx] = 1'b0;
					n_cur       = nx;
					r_new       = nx;
					r_sw        = 1'b1;
				end
			end
		endcase

		// tail push goes after any pop of the same request
		if (push_en) begin
			if (n_empty) begin
				n_head  = push_slot;
				n_tail  = push_slot;
				n_empty = 1'b0;
			end else begin
				link_we    = 1'b1;
				link_waddr = n_tail;
				link_wdata = push_slot;
				n_tail     = push_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			cur_q       <= '0;
			ready_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.req_type == fts_pkg::REQ_CREATE) ? S_FIND : S_EXEC;
					end
				end
				S_FIND: begin
					if (find_res.done) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_fire) begin
						head_q  <= n_head;
						tail_q  <= n_tail;
						empty_q <= n_empty;
						cur_q   <= n_cur;
						ready_q <= n_ready;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (exec_fire) begin
			rsp_q.status      <= r_status;
			rsp_q.new_pid     <= PW'(r_new);
			rsp_q.switched    <= r_sw;
			rsp_q.old_pid     <= PW'(cur_q);
			rsp_q.running_pid <= PW'(n_cur);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== sv/fts_link_ram.sv =====
// Next-link memory of the ready queue: one write port, one registered read port.
module fts_link_ram #(
	parameter int DEPTH = fts_pkg::DEF_NUM_SLOTS,
	parameter int W     = $clog2(fts_pkg::DEF_NUM_SLOTS)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/fts_free_search.sv =====
// Lowest-free-slot search, one chunk of the free map per cycle.
module fts_free_search #(
	parameter int NUM_SLOTS = fts_pkg::DEF_NUM_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [NUM_SLOTS-1:0]         free_vec,
	output fts_pkg::find_t               res,
	output logic [$clog2(NUM_SLOTS)-1:0] slot
);

	localparam int SLOT_W     = $clog2(NUM_SLOTS);
	localparam int CHUNK_N    = (NUM_SLOTS < fts_pkg::CHUNK_MAX) ? NUM_SLOTS : fts_pkg::CHUNK_MAX;
	localparam int NUM_CHUNKS = (NUM_SLOTS + CHUNK_N - 1) / CHUNK_N;
	localparam int CNT_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
	localparam int ENC_W      = (CHUNK_N > 1) ? $clog2(CHUNK_N) : 1;
	localparam int PAD_N      = NUM_CHUNKS * CHUNK_N;

	logic [PAD_N-1:0]   free_pad;
	logic [CHUNK_N-1:0] chunk_bits;
	logic [ENC_W-1:0]   enc;
	logic               hit;
	logic               last;
	logic               busy_q;
	logic [CNT_W-1:0]   chunk_q;
	logic               done_q;
	logic               found_q;
	logic [SLOT_W-1:0]  slot_q;

	assign free_pad   = PAD_N'(free_vec);
	assign chunk_bits = free_pad[int'(chunk_q) * CHUNK_N +: CHUNK_N];
	assign hit        = |chunk_bits;
	assign last       = (int'(chunk_q) == NUM_CHUNKS - 1);

	// priority encoder, lowest set bit wins
	always_comb begin
		enc = '0;
		for (int i = CHUNK_N - 1; i >= 0; i--) begin
			if (chunk_bits[i]) begin
				enc = ENC_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q  <= 1'b1;
				chunk_q <= '0;
				done_q  <= 1'b0;
			end else if (busy_q) begin
				if (hit || last) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					found_q <= hit;
				end else begin
					chunk_q <= chunk_q + 1'b1;
					done_q  <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && hit) begin
			slot_q <= SLOT_W'(int'(chunk_q) * CHUNK_N + int'(enc));
		end
	end

	assign res.done  = done_q;
	assign res.found = found_q;
	assign slot      = slot_q;

endmodule

// ===== sv/fts_checker.sv =====
// Port-level checks of the task scheduler, bound to the top level.
module fts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input fts_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input fts_pkg::rsp_t rsp
);

	// a stalled result beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat changed while stalled");

	// a create beat keeps the request side closed for the scan and the update
	a_create_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == fts_pkg::REQ_CREATE
		|=> !req_ready ##1 !req_ready ##1 !req_ready)
		else $error("request taken during create");

	a_switch_target: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.switched |-> rsp.new_pid == rsp.running_pid)
		else $error("switch target differs from running slot");

	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.switched |-> rsp.status == fts_pkg::ST_OK)
		else $error("switch reported with error status");

	// a refused request leaves the running slot alone
	a_refused_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != fts_pkg::ST_OK
		|-> !rsp.switched && rsp.old_pid == rsp.running_pid && rsp.new_pid == '0)
		else $error("refused request changed state");

endmodule

bind fifo_task_scheduler fts_checker u_fts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// ===== bench/fifo_task_scheduler_tb.sv =====
// Self-checking testbench for the FIFO task scheduler: directed and random requests.
`timescale 1ns / 1ps

module fifo_task_scheduler_tb;

	localparam int NSLOT       = fts_pkg::DEF_NUM_SLOTS;
	localparam int PW          = fts_pkg::PID_W;
	localparam int STALL_LIMIT = 1000;
	localparam int TAIL_CYCLES = 12;

	typedef enum logic [1:0] {
		SLOT_FREE  = 2'd0,
		SLOT_READY = 2'd1,
		SLOT_RUN   = 2'd2
	} slot_kind_t;

	typedef enum int {
		MIX_FILL,
		MIX_EVEN,
		MIX_DRAIN
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	fts_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	fts_pkg::rsp_t rsp;

	// scheduler state as predicted from the accepted requests
	slot_kind_t    slot_st [NSLOT];
	logic [PW-1:0] link_of [NSLOT];
	logic [PW-1:0] q_head;
	logic [PW-1:0] q_tail;
	logic          q_is_empty;
	logic [PW-1:0] cur_slot;

	fts_pkg::rsp_t pending_rsp [$];
	fts_pkg::rsp_t want_rsp;
	bit   idling = 1'b1;
	int   stall_left = 0;
	int   quiet_cycles = 0;
	int   err_cnt = 0;
	int   sent_cnt = 0;
	int   effective_cnt = 0;
	int   checked_cnt = 0;
	int   switch_cnt = 0;
	int   full_cnt = 0;
	int   none_ready_cnt = 0;

	fifo_task_scheduler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void queue_append(input logic [PW-1:0] s);
		if (q_is_empty) begin
			q_head = s;
			q_is_empty = 1'b0;
		end else begin
			link_of[q_tail] = s;
		end
		q_tail = s;
	endfunction

	function automatic logic [PW-1:0] queue_take();
		logic [PW-1:0] s;
		s = q_head;
		if (s == q_tail) begin
			q_is_empty = 1'b1;
			q_head = '0;
			q_tail = '0;
		end else begin
			q_head = link_of[s];
		end
		return s;
	endfunction

	// applies one request to the predicted table and returns the result it gives
	function automatic fts_pkg::rsp_t sched_apply(input fts_pkg::req_t r);
		fts_pkg::rsp_t o;
		int i;
		int found;
		logic [PW-1:0] prev;
		logic [PW-1:0] nxt;
		prev = cur_slot;
		o = '0;
		o.status = fts_pkg::ST_OK;
		o.old_pid = prev;
		case (r.req_type)
			fts_pkg::REQ_CREATE: begin
				found = 0;
				for (i = NSLOT - 1; i >= 1; i--)
					if (slot_st[i] == SLOT_FREE) found = i;
				if (found == 0) begin
					o.status = fts_pkg::ST_NO_SLOT;
				end else if (!r.stack_granted) begin
					o.status = fts_pkg::ST_NO_STACK;
				end else begin
					slot_st[found] = SLOT_READY;
					queue_append(PW'(found));
					o.new_pid = PW'(found);
				end
			end
			fts_pkg::REQ_READY: begin
				if (r.pid == 0 || r.pid == cur_slot || slot_st[r.pid] == SLOT_READY) begin
					o.status = fts_pkg::ST_IGNORED;
				end else begin
					slot_st[r.pid] = SLOT_READY;
					queue_append(r.pid);
				end
			end
			fts_pkg::REQ_YIELD: begin
				if (q_is_empty) begin
					o.status = fts_pkg::ST_NONE_READY;
				end else begin
					nxt = queue_take();
					// running task goes back to the tail, behind the others
					if (prev != 0 && slot_st[prev] == SLOT_RUN) begin
						slot_st[prev] = SLOT_READY;
						queue_append(prev);
					end
					slot_st[nxt] = SLOT_RUN;
					cur_slot = nxt;
					o.new_pid = nxt;
					o.switched = 1'b1;
				end
			end
			default: begin
				if (prev == 0) begin
					o.status = fts_pkg::ST_IGNORED;
				end else begin
					slot_st[prev] = SLOT_FREE;
					nxt = '0;
					if (!q_is_empty) nxt = queue_take();
					slot_st[nxt] = SLOT_RUN;
					cur_slot = nxt;
					o.new_pid = nxt;
					o.switched = 1'b1;
				end
			end
		endcase
		o.running_pid = cur_slot;
		return o;
	endfunction

	// mostly no gap, some short ones, a few long
	function automatic int idle_gap();
		int roll;
		if (!idling) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic fts_pkg::req_t mk_req(input fts_pkg::req_kind_t kind, input int pid,
			input bit granted);
		fts_pkg::req_t r;
		r.req_type = kind;
		r.pid = PW'(pid);
		r.stack_granted = granted;
		return r;
	endfunction

	function automatic fts_pkg::req_t random_req(input mix_t mix);
		int w_create;
		int w_ready;
		int w_yield;
		int roll;
		fts_pkg::req_kind_t kind;
		case (mix)
			MIX_FILL: begin w_create = 50; w_ready = 20; w_yield = 20; end
			MIX_DRAIN: begin w_create = 10; w_ready = 20; w_yield = 30; end
			default: begin w_create = 25; w_ready = 25; w_yield = 25; end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < w_create) kind = fts_pkg::REQ_CREATE;
		else if (roll < w_create + w_ready) kind = fts_pkg::REQ_READY;
		else if (roll < w_create + w_ready + w_yield) kind = fts_pkg::REQ_YIELD;
		else kind = fts_pkg::REQ_EXIT;
		return mk_req(kind, $urandom_range(0, 15), $urandom_range(0, 9) != 0);
	endfunction

	// valid stays up when the next beat follows with no gap
	task automatic send_req(input fts_pkg::req_t item);
		fts_pkg::rsp_t want;
		int gap;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		want = sched_apply(item);
		pending_rsp.push_back(want);
		sent_cnt++;
		if (want.status != fts_pkg::ST_IGNORED) effective_cnt++;
		if (want.status == fts_pkg::ST_NO_SLOT) full_cnt++;
		if (want.status == fts_pkg::ST_NONE_READY) none_ready_cnt++;
		gap = idle_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic test_empty_table();
		send_req(mk_req(fts_pkg::REQ_YIELD, 0, 1'b1));
		send_req(mk_req(fts_pkg::REQ_EXIT, 15, 1'b1));
		send_req(mk_req(fts_pkg::REQ_READY, 0, 1'b1));
		send_req(mk_req(fts_pkg::REQ_CREATE, 15, 1'b0));
	endtask

	task automatic test_full_table();
		int i;
		for (i = 1; i < NSLOT; i++)
			send_req(mk_req(fts_pkg::REQ_CREATE, i, 1'b1));
		send_req(mk_req(fts_pkg::REQ_CREATE, 0, 1'b1));
		send_req(mk_req(fts_pkg::REQ_READY, 15, 1'b0));
		send_req(mk_req(fts_pkg::REQ_YIELD, 0, 1'b0));
		send_req(mk_req(fts_pkg::REQ_READY, 1, 1'b1));
		send_req(mk_req(fts_pkg::REQ_EXIT, 0, 1'b0));
		// freed slot queued by make-ready, no create in between
		send_req(mk_req(fts_pkg::REQ_READY, 1, 1'b0));
		send_req(mk_req(fts_pkg::REQ_CREATE, 0, 1'b0));
	endtask

	task automatic test_random_mix(input int goal);
		int target;
		int n;
		mix_t mix;
		target = effective_cnt + goal;
		n = 0;
		mix = MIX_EVEN;
		while (effective_cnt < target) begin
			if (n % 40 == 0) mix = mix_t'($urandom_range(0, 2));
			send_req(random_req(mix));
			n++;
		end
	endtask

	task automatic test_back_to_back(input int count);
		int i;
		idling = 1'b0;
		for (i = 0; i < count; i++)
			send_req(random_req(MIX_EVEN));
		idling = 1'b1;
	endtask

	task automatic field_check(input string name, input logic [PW-1:0] e,
			input logic [PW-1:0] g);
		if (g !== e) begin
			$display("%0t: %s expected %0d got %0d", $time, name, e, g);
			err_cnt++;
		end
	endtask

	// result side: random stalls on ready, compare each beat with the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %p", $time, rsp);
					err_cnt++;
				end else begin
					want_rsp = pending_rsp.pop_front();
					field_check("status", want_rsp.status, rsp.status);
					field_check("new_pid", want_rsp.new_pid, rsp.new_pid);
					field_check("switched", want_rsp.switched, rsp.switched);
					field_check("old_pid", want_rsp.old_pid, rsp.old_pid);
					field_check("running_pid", want_rsp.running_pid, rsp.running_pid);
					checked_cnt++;
					if (want_rsp.switched) switch_cnt++;
				end
			end
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = idle_gap();
				rsp_ready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding",
					$time, STALL_LIMIT, pending_rsp.size());
				$display("fifo_task_scheduler_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			slot_st[i] = SLOT_FREE;
			link_of[i] = '0;
		end
		slot_st[0] = SLOT_RUN;
		q_head = '0;
		q_tail = '0;
		q_is_empty = 1'b1;
		cur_slot = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_full_table();
		test_random_mix(360);
		test_back_to_back(60);

		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests (%0d took effect), %0d results checked, %0d switches",
			sent_cnt, effective_cnt, checked_cnt, switch_cnt);
		$display("table full on %0d creates, queue empty on %0d yields",
			full_cnt, none_ready_cnt);
		if (err_cnt == 0)
			$display("fifo_task_scheduler_tb: done, clean");
		else
			$display("fifo_task_scheduler_tb: done, errors");
		$finish;
	end

endmodule

// ===== fifo_task_scheduler.f =====
sv/fts_pkg.sv
sv/fts_link_ram.sv
sv/fts_free_search.sv
sv/fifo_task_scheduler.sv
sv/fts_checker.sv
bench/fifo_task_scheduler_tb.sv
